/* rtl/lzsd_pkg.sv */
// Package with the constants, codes and controller/datapath types of the LZSS decompressor.
`default_nettype none

package lzsd_pkg;

  localparam int unsigned HIST_DEPTH = 4096;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned LANES      = 8;
  localparam int unsigned LANE_AW    = $clog2(LANES);
  localparam int unsigned CNT_W      = $clog2(LANES + 1);
  localparam int unsigned LIMIT_W    = 24;
  localparam int unsigned LEN_W      = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hFF_FFFF;
  localparam logic [7:0]         FLAG_FILL   = 8'hFF;
  localparam logic [3:0]         LEN_ESCAPE  = 4'hF;
  localparam logic [LEN_W-1:0]   LEN_MIN     = 9'd3;
  localparam logic [LEN_W-1:0]   LEN_EXT     = 9'd18;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_EXTRA = 2'd2,
    PH_TOKEN = 2'd3
  } lzsd_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR
  } lzsd_state_e;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic copy_emit;
  } lzsd_cmd_t;

  typedef struct packed {
    logic start_copy;
    logic out_free;
    logic emit_stall;
    logic copy_done;
  } lzsd_sts_t;

endpackage

`default_nettype wire

/* rtl/lzsd_in_if.sv */
// Interface for the compressed input channel.
`default_nettype none

interface lzsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_block;

  modport source (output valid, output data_byte, output start_of_block, input ready);
  modport sink (input valid, input data_byte, input start_of_block, output ready);
endinterface

`default_nettype wire

/* rtl/lzsd_out_if.sv */
// Interface for the decompressed output channel.
`default_nettype none

interface lzsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  out_byte_0;
  logic [7:0]                  out_byte_1;
  logic [7:0]                  out_byte_2;
  logic [7:0]                  out_byte_3;
  logic [7:0]                  out_byte_4;
  logic [7:0]                  out_byte_5;
  logic [7:0]                  out_byte_6;
  logic [7:0]                  out_byte_7;
  logic [lzsd_pkg::CNT_W-1:0]  byte_count;
  logic                        last_of_run;
  logic                        limit_reached;

  modport source (
    output valid, output out_byte_0, output out_byte_1, output out_byte_2,
    output out_byte_3, output out_byte_4, output out_byte_5, output out_byte_6,
    output out_byte_7, output byte_count, output last_of_run, output limit_reached,
    input ready
  );
  modport sink (
    input valid, input out_byte_0, input out_byte_1, input out_byte_2,
    input out_byte_3, input out_byte_4, input out_byte_5, input out_byte_6,
    input out_byte_7, input byte_count, input last_of_run, input limit_reached,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/lzss_stream_decompressor.sv */
// Top level of the LZSS stream decompressor with a 4096-byte circular history.
// Flag bytes, literal bytes and the first bytes of a back-reference are taken at one beat per
// cycle whenever the output register is free or being drained. A back-reference holds off the
// input while it copies from the 4096 x 8 history RAM: each copied byte is read from the RAM
// in ST_COPY_RD, then placed in the output lanes and written back in ST_COPY_WR, where the
// copy waits while the output side stalls. History entries read as zero until first written; a
// write pointer and wrap flag keep track of this, so no clearing pass is needed after reset.
`default_nettype none

module lzss_stream_decompressor (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lzsd_pkg::LIMIT_W-1:0] cfg_data_i,
  lzsd_in_if.sink                           in_i,
  lzsd_out_if.source                        out_o
);

  lzsd_pkg::lzsd_cmd_t cmd;
  lzsd_pkg::lzsd_sts_t sts;
  logic                in_ready;

  lzsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lzsd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_i.data_byte),
    .in_sob_i   (in_i.start_of_block),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_o)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

/* rtl/lzsd_ctrl.sv */
// Controller state machine that sequences input beats and history copies.
`default_nettype none

module lzsd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lzsd_pkg::lzsd_sts_t sts_i,
  output lzsd_pkg::lzsd_cmd_t     cmd_o
);

  lzsd_pkg::lzsd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzsd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lzsd_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.out_free && sts_i.start_copy) begin
          state_d = lzsd_pkg::ST_COPY_RD;
        end
      end
      lzsd_pkg::ST_COPY_RD: begin
        state_d = lzsd_pkg::ST_COPY_WR;
      end
      lzsd_pkg::ST_COPY_WR: begin
        if (sts_i.copy_done) begin
          state_d = lzsd_pkg::ST_IDLE;
        end else if (!sts_i.emit_stall) begin
          state_d = lzsd_pkg::ST_COPY_RD;
        end
      end
      default: begin
        state_d = lzsd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == lzsd_pkg::ST_IDLE) && sts_i.out_free;
    cmd_o.accept    = in_ready_o && in_valid_i;
    cmd_o.rd_en     = (state_q == lzsd_pkg::ST_COPY_RD);
    cmd_o.copy_emit = (state_q == lzsd_pkg::ST_COPY_WR);
  end

endmodule

`default_nettype wire

/* rtl/lzsd_datapath.sv */
// Datapath with token decode, history memory, byte counter and output packing register.
`default_nettype none

module lzsd_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lzsd_pkg::LIMIT_W-1:0] cfg_data_i,
  input  wire logic [7:0]                   in_data_i,
  input  wire logic                         in_sob_i,
  input  wire lzsd_pkg::lzsd_cmd_t          cmd_i,
  output lzsd_pkg::lzsd_sts_t               sts_o,
  lzsd_out_if.source                        out_o
);

  localparam int unsigned AW = lzsd_pkg::HIST_AW;
  localparam int unsigned LW = lzsd_pkg::LIMIT_W;
  localparam int unsigned NW = lzsd_pkg::LEN_W;

  logic [7:0]                  hist_mem [lzsd_pkg::HIST_DEPTH];
  logic [7:0]                  rdata_q;
  logic                        rd_ok_q;
  logic [AW-1:0]               wp_q, wp_d;
  logic                        wrapped_q, wrapped_d;
  logic [15:0]                 flag_q, flag_d;
  lzsd_pkg::lzsd_phase_e       phase_q, phase_d;
  logic [7:0]                  low_q, low_d;
  logic [7:0]                  high_q, high_d;
  logic [LW-1:0]               count_q, count_d;
  logic                        stopped_q, stopped_d;
  logic [LW-1:0]               limit_q;
  logic [AW-1:0]               pos_q, pos_d;
  logic [NW-1:0]               rem_q, rem_d;
  logic [7:0]                  lanes_q [lzsd_pkg::LANES];
  logic [7:0]                  lanes_d [lzsd_pkg::LANES];
  logic [lzsd_pkg::LANE_AW-1:0] fill_q, fill_d;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  obyte_q [lzsd_pkg::LANES];
  logic [7:0]                  obyte_d [lzsd_pkg::LANES];
  logic [lzsd_pkg::CNT_W-1:0]  ocount_q, ocount_d;
  logic                        olast_q, olast_d;
  logic                        olimit_q, olimit_d;

  logic                        sob;
  logic [15:0]                 flag_eff, flag_sh;
  lzsd_pkg::lzsd_phase_e       phase_eff;
  logic                        stop_eff;
  logic [LW-1:0]               cnt_eff, cnt_next;
  logic                        lit_req, emit_req, emit_last, do_emit;
  logic [7:0]                  emit_byte;
  logic                        limit_hit, stop_new, close_res;
  logic                        start_copy;
  logic [AW-1:0]               copy_pos;
  logic [NW-1:0]               copy_len;
  logic [NW-1:0]               short_len;

  always_comb begin
    sob       = cmd_i.accept && in_sob_i;
    flag_eff  = sob ? 16'h0000 : flag_q;
    phase_eff = sob ? lzsd_pkg::PH_FLAG : phase_q;
    stop_eff  = sob ? 1'b0 : stopped_q;
    cnt_eff   = sob ? '0 : count_q;
    flag_sh   = {1'b0, flag_eff[15:1]};
    short_len = lzsd_pkg::LEN_MIN + {{(NW - 4){1'b0}}, in_data_i[7:4]};

    flag_d     = flag_eff;
    phase_d    = phase_eff;
    low_d      = low_q;
    high_d     = high_q;
    lit_req    = 1'b0;
    start_copy = 1'b0;
    copy_pos   = {high_q[3:0], low_q};
    copy_len   = short_len;

    if (!stop_eff) begin
      unique case (phase_eff)
        lzsd_pkg::PH_FLAG: begin
          if (!flag_sh[8]) begin
            flag_d  = {lzsd_pkg::FLAG_FILL, in_data_i};
            phase_d = lzsd_pkg::PH_TOKEN;
          end else begin
            flag_d = flag_sh;
            if (flag_sh[0]) begin
              low_d   = in_data_i;
              phase_d = lzsd_pkg::PH_HIGH;
            end else begin
              lit_req = 1'b1;
              phase_d = lzsd_pkg::PH_FLAG;
            end
          end
        end
        lzsd_pkg::PH_TOKEN: begin
          if (flag_eff[0]) begin
            low_d   = in_data_i;
            phase_d = lzsd_pkg::PH_HIGH;
          end else begin
            lit_req = 1'b1;
            phase_d = lzsd_pkg::PH_FLAG;
          end
        end
        lzsd_pkg::PH_HIGH: begin
          high_d = in_data_i;
          if (in_data_i[7:4] == lzsd_pkg::LEN_ESCAPE) begin
            phase_d = lzsd_pkg::PH_EXTRA;
          end else begin
            phase_d    = lzsd_pkg::PH_FLAG;
            start_copy = 1'b1;
            copy_pos   = {in_data_i[3:0], low_q};
            copy_len   = short_len;
          end
        end
        default: begin
          phase_d    = lzsd_pkg::PH_FLAG;
          start_copy = 1'b1;
          copy_pos   = {high_q[3:0], low_q};
          copy_len   = lzsd_pkg::LEN_EXT + {1'b0, in_data_i};
        end
      endcase
    end

    emit_req  = (cmd_i.accept && lit_req) || cmd_i.copy_emit;
    emit_byte = cmd_i.copy_emit ? (rd_ok_q ? rdata_q : 8'h00) : in_data_i;
    emit_last = cmd_i.copy_emit ? (rem_q == NW'(1)) : 1'b1;
    limit_hit = cnt_eff >= limit_q;
    cnt_next  = cnt_eff + LW'(1);
    stop_new  = cnt_next >= limit_q;
    close_res = emit_req && !limit_hit &&
                ((fill_q == lzsd_pkg::LANE_AW'(lzsd_pkg::LANES - 1)) || stop_new || emit_last);

    sts_o.out_free   = !out_valid_q || out_o.ready;
    sts_o.emit_stall = close_res && !sts_o.out_free;
    sts_o.start_copy = start_copy;
    do_emit          = emit_req && !limit_hit && !sts_o.emit_stall;
    sts_o.copy_done  = cmd_i.copy_emit && !sts_o.emit_stall &&
                       (limit_hit || emit_last || stop_new);
  end

  always_comb begin
    wp_d        = wp_q;
    wrapped_d   = wrapped_q;
    count_d     = cmd_i.accept ? cnt_eff : count_q;
    stopped_d   = cmd_i.accept ? stop_eff : stopped_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    lanes_d     = lanes_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_o.ready;
    obyte_d     = obyte_q;
    ocount_d    = ocount_q;
    olast_d     = olast_q;
    olimit_d    = olimit_q;

    if (cmd_i.accept && start_copy) begin
      pos_d = copy_pos;
      rem_d = copy_len;
    end
    if (emit_req && limit_hit) begin
      stopped_d = 1'b1;
    end
    if (cmd_i.copy_emit && !sts_o.emit_stall) begin
      pos_d = pos_q + AW'(1);
      rem_d = rem_q - NW'(1);
    end
    if (do_emit) begin
      wp_d    = wp_q + AW'(1);
      count_d = cnt_next;
      if (wp_q == {AW{1'b1}}) begin
        wrapped_d = 1'b1;
      end
      if (stop_new) begin
        stopped_d = 1'b1;
      end
      if (close_res) begin
        obyte_d         = lanes_q;
        obyte_d[fill_q] = emit_byte;
        ocount_d        = lzsd_pkg::CNT_W'(fill_q) + lzsd_pkg::CNT_W'(1);
        olast_d         = emit_last || stop_new;
        olimit_d        = stop_new;
        out_valid_d     = 1'b1;
        fill_d          = '0;
        for (int i = 0; i < int'(lzsd_pkg::LANES); i++) begin
          lanes_d[i] = 8'h00;
        end
      end else begin
        lanes_d[fill_q] = emit_byte;
        fill_d          = fill_q + lzsd_pkg::LANE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      flag_q      <= 16'h0000;
      phase_q     <= lzsd_pkg::PH_FLAG;
      low_q       <= 8'h00;
      high_q      <= 8'h00;
      count_q     <= '0;
      stopped_q   <= 1'b0;
      limit_q     <= lzsd_pkg::LIMIT_RESET;
      pos_q       <= '0;
      rem_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(lzsd_pkg::LANES); i++) begin
        lanes_q[i] <= 8'h00;
      end
    end else begin
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
      count_q     <= count_d;
      stopped_q   <= stopped_d;
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      lanes_q     <= lanes_d;
      if (cmd_i.accept) begin
        flag_q  <= flag_d;
        phase_q <= phase_d;
        low_q   <= low_d;
        high_q  <= high_d;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q  <= obyte_d;
    ocount_q <= ocount_d;
    olast_q  <= olast_d;
    olimit_q <= olimit_d;
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      hist_mem[wp_q] <= emit_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= hist_mem[pos_q];
      rd_ok_q <= wrapped_q || (pos_q < wp_q);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte_0    = obyte_q[0];
  assign out_o.out_byte_1    = obyte_q[1];
  assign out_o.out_byte_2    = obyte_q[2];
  assign out_o.out_byte_3    = obyte_q[3];
  assign out_o.out_byte_4    = obyte_q[4];
  assign out_o.out_byte_5    = obyte_q[5];
  assign out_o.out_byte_6    = obyte_q[6];
  assign out_o.out_byte_7    = obyte_q[7];
  assign out_o.byte_count    = ocount_q;
  assign out_o.last_of_run   = olast_q;
  assign out_o.limit_reached = olimit_q;

endmodule

`default_nettype wire

/* rtl/lzsd_checker.sv */
// Checker on the output ports of the decompressor, bound to the top level.
`default_nettype none

module lzsd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        valid_i,
  input wire logic                        ready_i,
  input wire logic [lzsd_pkg::CNT_W-1:0]  byte_count_i,
  input wire logic                        last_of_run_i,
  input wire logic                        limit_reached_i
);

  localparam logic [lzsd_pkg::CNT_W-1:0] FULL = lzsd_pkg::CNT_W'(lzsd_pkg::LANES);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(byte_count_i))
    else $error("Output beat changed while stalled.");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (byte_count_i != '0) && (byte_count_i <= FULL))
    else $error("Output beat has a byte count out of range.");

  a_limit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && limit_reached_i |-> last_of_run_i)
    else $error("Limit reached on a beat that is not the last of its run.");

  a_partial_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (byte_count_i != FULL) |-> last_of_run_i)
    else $error("Partly filled beat is not the last of its run.");

endmodule

bind lzss_stream_decompressor lzsd_checker u_lzsd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (out_o.valid),
  .ready_i         (out_o.ready),
  .byte_count_i    (out_o.byte_count),
  .last_of_run_i   (out_o.last_of_run),
  .limit_reached_i (out_o.limit_reached)
);

`default_nettype wire
